// ----- rtl/rtwd_pkg.sv -----
// package for the readout trailer word decoder
// types, field codes and markers shared by the decoder, the record emitter and the top level
// depends on nothing
`default_nettype none

package rtwd_pkg;

    // word markers, bits 31:30
    localparam logic [1:0] MARK_LAST  = 2'd3;
    localparam logic [1:0] MARK_PARAM = 2'd2;

    // record status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_MARKER = 2'd1;
    localparam logic [1:0] ST_BAD_SIZE  = 2'd2;
    localparam logic [1:0] ST_CORRUPT   = 2'd3;

    // parameter word codes, bits 29:26
    localparam logic [3:0] PCODE_FEC       = 4'd1;
    localparam logic [3:0] PCODE_REG_TWO   = 4'd2;
    localparam logic [3:0] PCODE_REG_THREE = 4'd3;
    localparam logic [3:0] PCODE_ACT_A     = 4'd4;
    localparam logic [3:0] PCODE_ACT_B     = 4'd5;
    localparam logic [3:0] PCODE_CFG_ONE   = 4'd6;
    localparam logic [3:0] PCODE_CFG_TWO   = 4'd7;

    localparam logic [6:0]  MIN_SIZE    = 7'd2;
    localparam logic [15:0] CORRUPT_MAX = 16'hFFFF;

    typedef enum logic [3:0] {
        FLD_UNIT_ID,
        FLD_FW_VERSION,
        FLD_SIZE,
        FLD_PAYLOAD,
        FLD_FEC_A,
        FLD_FEC_B,
        FLD_REG_TWO,
        FLD_REG_THREE,
        FLD_ACT_A,
        FLD_ACT_B,
        FLD_CFG_ONE,
        FLD_CFG_TWO,
        FLD_CORRUPT
    } field_id_t;

    typedef struct packed {
        logic [31:0] word;
        logic        start_req;
    } word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  field_id;
        logic [25:0] field_value;
        logic        last;
    } record_t;

    // decoded trailer contents
    typedef struct packed {
        logic [8:0]  unit_id;
        logic [7:0]  fw_version;
        logic [6:0]  size_words;
        logic [25:0] payload_len;
        logic [19:0] fec_error_a;
        logic [19:0] fec_error_b;
        logic [8:0]  error_reg_two;
        logic [24:0] error_reg_three;
        logic [15:0] active_cards_a;
        logic [15:0] active_cards_b;
        logic [19:0] readout_cfg_one;
        logic [24:0] readout_cfg_two;
        logic [15:0] corrupt_words;
    } report_t;

    // one result event handed from decoder to emitter
    typedef struct packed {
        logic        is_report;
        logic [1:0]  status;
        logic [25:0] err_value;
        report_t     rpt;
    } event_t;

endpackage

`default_nettype wire

// ----- rtl/rtwd_decode.sv -----
// trailer word decoder: holds the trailer state and turns each word into an optional event
// depends on rtwd_pkg
`default_nettype none

module rtwd_decode (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire rtwd_pkg::word_t word_data,
    output logic                evt_hit,
    output rtwd_pkg::event_t    evt
);

    logic              collecting_reg, collecting_next;
    logic [6:0]        left_reg, left_next;
    logic [6:0]        found_reg, found_next;
    rtwd_pkg::report_t rpt_reg, rpt_next;

    logic [31:0]       w;
    logic [1:0]        marker;
    logic [6:0]        sz;
    logic [6:0]        found_last;
    logic              short_trailer;
    rtwd_pkg::report_t rpt_last;

    always_comb
    begin
        w      = word_data.word;
        marker = w[31:30];
        sz     = w[6:0];

        // last word of the trailer: payload size
        rpt_last = rpt_reg;
        if (marker == rtwd_pkg::MARK_PARAM)
        begin
            rpt_last.payload_len = w[25:0];
        end
        found_last    = found_reg + 7'((marker == rtwd_pkg::MARK_PARAM) ? 1 : 0);
        short_trailer = ({1'b0, found_last} + 8'd1) < {1'b0, rpt_reg.size_words};

        // event for this word
        evt           = '0;
        evt.rpt       = rpt_last;
        evt_hit       = 1'b0;
        if (word_data.start_req)
        begin
            if (marker != rtwd_pkg::MARK_LAST)
            begin
                evt_hit    = 1'b1;
                evt.status = rtwd_pkg::ST_NO_MARKER;
            end
            else if (sz < rtwd_pkg::MIN_SIZE)
            begin
                evt_hit       = 1'b1;
                evt.status    = rtwd_pkg::ST_BAD_SIZE;
                evt.err_value = 26'(sz);
            end
        end
        else if (collecting_reg && (left_reg == 7'd0))
        begin
            evt_hit = 1'b1;
            if (short_trailer)
            begin
                evt.status    = rtwd_pkg::ST_CORRUPT;
                evt.err_value = 26'(rpt_reg.size_words - found_last);
            end
            else
            begin
                evt.is_report = 1'b1;
                evt.status    = rtwd_pkg::ST_OK;
            end
        end

        // state update
        collecting_next = collecting_reg;
        left_next       = left_reg;
        found_next      = found_reg;
        rpt_next        = rpt_reg;
        if (accept)
        begin
            if (word_data.start_req)
            begin
                rpt_next               = '0;
                rpt_next.corrupt_words = rpt_reg.corrupt_words;
                collecting_next        = 1'b0;
                left_next              = 7'd0;
                found_next             = 7'd0;
                if ((marker == rtwd_pkg::MARK_LAST) && (sz >= rtwd_pkg::MIN_SIZE))
                begin
                    rpt_next.fw_version = w[23:16];
                    rpt_next.unit_id    = w[15:7];
                    rpt_next.size_words = sz;
                    left_next           = sz - rtwd_pkg::MIN_SIZE;
                    collecting_next     = 1'b1;
                end
            end
            else if (collecting_reg && (left_reg != 7'd0))
            begin
                left_next = left_reg - 7'd1;
                if (marker == rtwd_pkg::MARK_PARAM)
                begin
                    found_next = found_reg + 7'd1;
                    case (w[29:26])
                        rtwd_pkg::PCODE_FEC:
                        begin
                            rpt_next.fec_error_a = {w[25:13], 7'd0};
                            rpt_next.fec_error_b = {w[12:0], 7'd0};
                        end
                        rtwd_pkg::PCODE_REG_TWO:   rpt_next.error_reg_two   = w[8:0];
                        rtwd_pkg::PCODE_REG_THREE: rpt_next.error_reg_three = w[24:0];
                        rtwd_pkg::PCODE_ACT_A:     rpt_next.active_cards_a  = w[15:0];
                        rtwd_pkg::PCODE_ACT_B:     rpt_next.active_cards_b  = w[15:0];
                        rtwd_pkg::PCODE_CFG_ONE:   rpt_next.readout_cfg_one = w[19:0];
                        rtwd_pkg::PCODE_CFG_TWO:   rpt_next.readout_cfg_two = w[24:0];
                        default:
                        begin
                            if (rpt_reg.corrupt_words != rtwd_pkg::CORRUPT_MAX)
                            begin
                                rpt_next.corrupt_words = rpt_reg.corrupt_words + 16'd1;
                            end
                        end
                    endcase
                end
            end
            else if (collecting_reg)
            begin
                rpt_next        = rpt_last;
                found_next      = found_last;
                collecting_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collecting_reg <= 1'b0;
            left_reg       <= 7'd0;
            found_reg      <= 7'd0;
            rpt_reg        <= '0;
        end
        else
        begin
            collecting_reg <= collecting_next;
            left_reg       <= left_next;
            found_reg      <= found_next;
            rpt_reg        <= rpt_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rtwd_emit.sv -----
// record emitter: one event slot and the output register, walks a report field by field
// depends on rtwd_pkg
`default_nettype none

module rtwd_emit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire rtwd_pkg::event_t evt,
    output logic                  evt_free,
    output logic                  evt_busy,
    output logic                  record_valid,
    input  wire logic             record_stall,
    output rtwd_pkg::record_t     record_data
);

    logic               evt_valid_reg, evt_valid_next;
    rtwd_pkg::event_t   evt_reg;
    logic [3:0]         idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    rtwd_pkg::record_t  out_reg;

    logic               load;
    logic               done;
    rtwd_pkg::record_t  rec;
    logic [25:0]        fval;

    always_comb
    begin
        case (rtwd_pkg::field_id_t'(idx_reg))
            rtwd_pkg::FLD_UNIT_ID:    fval = 26'(evt_reg.rpt.unit_id);
            rtwd_pkg::FLD_FW_VERSION: fval = 26'(evt_reg.rpt.fw_version);
            rtwd_pkg::FLD_SIZE:       fval = 26'(evt_reg.rpt.size_words);
            rtwd_pkg::FLD_PAYLOAD:    fval = evt_reg.rpt.payload_len;
            rtwd_pkg::FLD_FEC_A:      fval = 26'(evt_reg.rpt.fec_error_a);
            rtwd_pkg::FLD_FEC_B:      fval = 26'(evt_reg.rpt.fec_error_b);
            rtwd_pkg::FLD_REG_TWO:    fval = 26'(evt_reg.rpt.error_reg_two);
            rtwd_pkg::FLD_REG_THREE:  fval = 26'(evt_reg.rpt.error_reg_three);
            rtwd_pkg::FLD_ACT_A:      fval = 26'(evt_reg.rpt.active_cards_a);
            rtwd_pkg::FLD_ACT_B:      fval = 26'(evt_reg.rpt.active_cards_b);
            rtwd_pkg::FLD_CFG_ONE:    fval = 26'(evt_reg.rpt.readout_cfg_one);
            rtwd_pkg::FLD_CFG_TWO:    fval = 26'(evt_reg.rpt.readout_cfg_two);
            rtwd_pkg::FLD_CORRUPT:    fval = 26'(evt_reg.rpt.corrupt_words);
            default:                  fval = '0;
        endcase

        if (evt_reg.is_report)
        begin
            rec.status      = rtwd_pkg::ST_OK;
            rec.field_id    = idx_reg;
            rec.field_value = fval;
            rec.last        = (idx_reg == 4'(rtwd_pkg::FLD_CORRUPT));
        end
        else
        begin
            rec.status      = evt_reg.status;
            rec.field_id    = 4'(rtwd_pkg::FLD_UNIT_ID);
            rec.field_value = evt_reg.err_value;
            rec.last        = 1'b1;
        end

        load     = evt_valid_reg && (!out_valid_reg || !record_stall);
        done     = load && rec.last;
        evt_free = !evt_valid_reg || done;
        evt_busy = evt_valid_reg;

        evt_valid_next = push || (evt_valid_reg && !done);
        if (done)
        begin
            idx_next = 4'd0;
        end
        else if (load)
        begin
            idx_next = idx_reg + 4'd1;
        end
        else
        begin
            idx_next = idx_reg;
        end
        out_valid_next = load || (out_valid_reg && record_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
            idx_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            evt_valid_reg <= evt_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            evt_reg <= evt;
        end
        if (load)
        begin
            out_reg <= rec;
        end
    end

    assign record_valid = out_valid_reg;
    assign record_data  = out_reg;

endmodule

`default_nettype wire

// ----- rtl/readout_trailer_word_decoder_unit.sv -----
// readout trailer word decoder: one word per cycle unless word_stall is high; records leave
// through the event slot and then the output register, once the word that causes them is taken
// throughput: a full report leaves as thirteen records, and a further result-causing word
//   waits only while the event slot is still draining
// reset: rst_n clears the trailer state, the corruption counter, the event slot and output valid
// depends on rtwd_pkg, rtwd_decode and rtwd_emit
`default_nettype none

module readout_trailer_word_decoder_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // word channel
    input  wire logic              word_valid,
    output logic                   word_stall,
    input  wire rtwd_pkg::word_t   word_data,
    // record channel
    output logic                   record_valid,
    input  wire logic              record_stall,
    output rtwd_pkg::record_t      record_data
);

    logic             accept;
    logic             evt_hit;
    logic             evt_free;
    logic             evt_busy;
    logic             push;
    rtwd_pkg::event_t evt;

    // a word that causes no record is always taken; one that causes a record
    // needs the event slot to be empty or emptying in this cycle
    assign word_stall = evt_hit && !evt_free;
    assign accept     = word_valid && !word_stall;
    assign push       = accept && evt_hit;

    // trailer state and per-word field extraction
    rtwd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .word_data (word_data),
        .evt_hit   (evt_hit),
        .evt       (evt)
    );

    // event slot plus output register, steps through report fields one per transfer
    rtwd_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .evt          (evt),
        .evt_free     (evt_free),
        .evt_busy     (evt_busy),
        .record_valid (record_valid),
        .record_stall (record_stall),
        .record_data  (record_data)
    );

`ifndef SYNTHESIS
    // an event is only pushed into a slot that is free or freeing
    assert property (@(posedge clk) disable iff (!rst_n)
        push && evt_busy |-> evt_free)
        else $error("event pushed over a pending event");

    // the records of one report follow without a gap
    assert property (@(posedge clk) disable iff (!rst_n)
        record_valid && !record_stall && !record_data.last |=> record_valid)
        else $error("gap inside a report");

    // report fields come out in order
    assert property (@(posedge clk) disable iff (!rst_n)
        record_valid && !record_stall && !record_data.last
        |=> record_data.field_id == $past(record_data.field_id) + 4'd1)
        else $error("report field out of order");
`endif

endmodule

`default_nettype wire

// ----- bench/readout_trailer_word_decoder_unit_tb.sv -----
// testbench for readout_trailer_word_decoder_unit: directed and random trailers
// checked record by record against a predictor of the decoder kept in this file
// depends on rtwd_pkg and the readout_trailer_word_decoder_unit rtl
`default_nettype none

module readout_trailer_word_decoder_unit_tb;

    // markers with no meaning to the decoder, and parameter codes it treats as corrupt
    localparam logic [1:0] MARK_NONE   = 2'd0;
    localparam logic [1:0] MARK_OTHER  = 2'd1;
    localparam logic [3:0] PCODE_NONE  = 4'd0;
    localparam logic [3:0] PCODE_TOP   = 4'd15;
    // error records carry a zero field code
    localparam logic [3:0] NO_FIELD    = 4'd0;
    localparam logic [6:0] MAX_SIZE    = 7'd127;

    localparam int IDLE_PERCENT   = 16;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int STUCK_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int ITEM_TARGET    = 160;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              word_valid   = 1'b0;
    logic              word_stall;
    rtwd_pkg::word_t   word_data    = '0;
    logic              record_valid;
    logic              record_stall = 1'b0;
    rtwd_pkg::record_t record_data;

    // records the decoder owes us, oldest first
    rtwd_pkg::record_t due_records[$];

    // predicted decoder state; the corruption count inside survives from trailer to trailer
    rtwd_pkg::report_t trailer_seen = '0;
    logic        gathering    = 1'b0;
    logic [6:0]  params_left  = '0;
    logic [6:0]  marked_count = '0;

    int          mismatch_count  = 0;
    int unsigned items_sent      = 0;
    int          quiet_cycles    = 0;
    int          holdoff_request = 0;
    int          holdoff_left    = 0;
    bit          no_gaps         = 1'b0;

    readout_trailer_word_decoder_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .word_valid   (word_valid),
        .word_stall   (word_stall),
        .word_data    (word_data),
        .record_valid (record_valid),
        .record_stall (record_stall),
        .record_data  (record_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // word builders
    // ------------------------------------------------------------------

    // final trailer word: marker, spare bits, firmware version, unit id, trailer size
    function automatic logic [31:0] make_last_word(logic [1:0] mark, logic [5:0] spare,
                                                   logic [7:0] fw, logic [8:0] id,
                                                   logic [6:0] size);
        return {mark, spare, fw, id, size};
    endfunction

    function automatic logic [31:0] make_param_word(logic [1:0] mark, logic [3:0] code,
                                                    logic [25:0] data);
        return {mark, code, data};
    endfunction

    // any marker the decoder does not take as a parameter word
    function automatic logic [1:0] stray_marker();
        logic [1:0] mark;
        mark = 2'($urandom_range(2));
        if (mark == rtwd_pkg::MARK_PARAM)
            mark = rtwd_pkg::MARK_LAST;
        return mark;
    endfunction

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    task automatic owe_record(input logic [1:0] st, input logic [3:0] id,
                              input logic [25:0] value, input logic fin);
        rtwd_pkg::record_t rec;
        rec.status      = st;
        rec.field_id    = id;
        rec.field_value = value;
        rec.last        = fin;
        due_records     = {due_records, rec};
    endtask

    // one field record of a good report; the corruption count closes the report
    task automatic owe_field(input rtwd_pkg::field_id_t id, input logic [25:0] value);
        owe_record(rtwd_pkg::ST_OK, 4'(id), value, id == rtwd_pkg::FLD_CORRUPT);
    endtask

    // work out what one transferred word does to the trailer and which records it owes
    task automatic decode_trailer_word(input rtwd_pkg::word_t item);
        logic [15:0] kept_corrupt;
        logic [3:0]  code;
        logic [25:0] data;
        if (item.start_req)
        begin
            // a start abandons whatever was in progress; only the corruption count is kept
            kept_corrupt = trailer_seen.corrupt_words;
            trailer_seen = '0;
            trailer_seen.corrupt_words = kept_corrupt;
            gathering    = 1'b0;
            params_left  = '0;
            marked_count = '0;
            if (item.word[31:30] != rtwd_pkg::MARK_LAST)
            begin
                owe_record(rtwd_pkg::ST_NO_MARKER, NO_FIELD, '0, 1'b1);
            end
            else if (item.word[6:0] < rtwd_pkg::MIN_SIZE)
            begin
                owe_record(rtwd_pkg::ST_BAD_SIZE, NO_FIELD, 26'(item.word[6:0]), 1'b1);
            end
            else
            begin
                trailer_seen.fw_version = item.word[23:16];
                trailer_seen.unit_id    = item.word[15:7];
                trailer_seen.size_words = item.word[6:0];
                params_left = item.word[6:0] - rtwd_pkg::MIN_SIZE;
                gathering   = 1'b1;
            end
        end
        else if (gathering && params_left != 0)
        begin
            params_left = params_left - 1'b1;
            if (item.word[31:30] == rtwd_pkg::MARK_PARAM)
            begin
                marked_count = marked_count + 1'b1;
                code = item.word[29:26];
                data = item.word[25:0];
                case (code)
                    rtwd_pkg::PCODE_FEC:
                    begin
                        trailer_seen.fec_error_a = {data[25:13], 7'b0};
                        trailer_seen.fec_error_b = {data[12:0], 7'b0};
                    end
                    rtwd_pkg::PCODE_REG_TWO:   trailer_seen.error_reg_two   = data[8:0];
                    rtwd_pkg::PCODE_REG_THREE: trailer_seen.error_reg_three = data[24:0];
                    rtwd_pkg::PCODE_ACT_A:     trailer_seen.active_cards_a  = data[15:0];
                    rtwd_pkg::PCODE_ACT_B:     trailer_seen.active_cards_b  = data[15:0];
                    rtwd_pkg::PCODE_CFG_ONE:   trailer_seen.readout_cfg_one = data[19:0];
                    rtwd_pkg::PCODE_CFG_TWO:   trailer_seen.readout_cfg_two = data[24:0];
                    default:
                    begin
                        if (trailer_seen.corrupt_words != rtwd_pkg::CORRUPT_MAX)
                            trailer_seen.corrupt_words = trailer_seen.corrupt_words + 1'b1;
                    end
                endcase
            end
        end
        else if (gathering)
        begin
            // payload-size word closes the trailer
            if (item.word[31:30] == rtwd_pkg::MARK_PARAM)
            begin
                trailer_seen.payload_len = item.word[25:0];
                marked_count = marked_count + 1'b1;
            end
            gathering = 1'b0;
            if (int'(marked_count) + 1 < int'(trailer_seen.size_words))
            begin
                owe_record(rtwd_pkg::ST_CORRUPT, NO_FIELD,
                           26'(trailer_seen.size_words - marked_count), 1'b1);
            end
            else
            begin
                owe_field(rtwd_pkg::FLD_UNIT_ID,    26'(trailer_seen.unit_id));
                owe_field(rtwd_pkg::FLD_FW_VERSION, 26'(trailer_seen.fw_version));
                owe_field(rtwd_pkg::FLD_SIZE,       26'(trailer_seen.size_words));
                owe_field(rtwd_pkg::FLD_PAYLOAD,    trailer_seen.payload_len);
                owe_field(rtwd_pkg::FLD_FEC_A,      26'(trailer_seen.fec_error_a));
                owe_field(rtwd_pkg::FLD_FEC_B,      26'(trailer_seen.fec_error_b));
                owe_field(rtwd_pkg::FLD_REG_TWO,    26'(trailer_seen.error_reg_two));
                owe_field(rtwd_pkg::FLD_REG_THREE,  26'(trailer_seen.error_reg_three));
                owe_field(rtwd_pkg::FLD_ACT_A,      26'(trailer_seen.active_cards_a));
                owe_field(rtwd_pkg::FLD_ACT_B,      26'(trailer_seen.active_cards_b));
                owe_field(rtwd_pkg::FLD_CFG_ONE,    26'(trailer_seen.readout_cfg_one));
                owe_field(rtwd_pkg::FLD_CFG_TWO,    26'(trailer_seen.readout_cfg_two));
                owe_field(rtwd_pkg::FLD_CORRUPT,    26'(trailer_seen.corrupt_words));
            end
        end
        // a word without start while idle is dropped by the decoder
    endtask

    // ------------------------------------------------------------------
    // word side: one transfer per call, random gaps in front unless gaps are off
    // ------------------------------------------------------------------

    task automatic send_word(input logic [31:0] w, input logic s);
        rtwd_pkg::word_t item;
        item.word      = w;
        item.start_req = s;
        while (!no_gaps && $urandom_range(99) < IDLE_PERCENT)
        begin
            word_valid <= 1'b0;
            @(posedge clk);
        end
        word_valid <= 1'b1;
        word_data  <= item;
        // values seen here are those before the edge, as the block saw them
        do
            @(posedge clk);
        while (word_stall);
        items_sent++;
        decode_trailer_word(item);
    endtask

    // sender stops and waits for every owed record; it checks only after the clock has ticked
    task automatic wait_drained();
        word_valid <= 1'b0;
        do
            @(posedge clk);
        while (due_records.size() != 0);
    endtask

    // one trailer of random content; a cut trailer stops early and leaves the decoder busy
    task automatic send_trailer(input int unsigned size_cap, input bit cut);
        int unsigned sz;
        int unsigned n_params;
        int unsigned k;
        logic [31:0] rnd;
        logic [1:0]  mark;
        logic [3:0]  code;
        sz = $urandom_range(size_cap, cut ? 3 : 2);
        n_params = cut ? $urandom_range(sz - 3, 0) : sz - 2;
        rnd = $urandom;
        send_word(make_last_word(rtwd_pkg::MARK_LAST, rnd[29:24], rnd[23:16], rnd[15:7],
                                 7'(sz)), 1'b1);
        for (k = 0; k < n_params; k++)
        begin
            rnd  = $urandom;
            mark = ($urandom_range(99) < 8) ? stray_marker() : rtwd_pkg::MARK_PARAM;
            // mostly known codes, now and then any code at all
            code = ($urandom_range(99) < 85) ? 4'($urandom_range(7, 1)) : rnd[29:26];
            send_word(make_param_word(mark, code, rnd[25:0]), 1'b0);
        end
        if (!cut)
        begin
            rnd  = $urandom;
            mark = ($urandom_range(99) < 90) ? rtwd_pkg::MARK_PARAM : stray_marker();
            send_word({mark, rnd[29:0]}, 1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // record side: random stalls, long hold-off on request, none while gaps are off
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (holdoff_left > 0)
        begin
            record_stall <= 1'b1;
            holdoff_left = holdoff_left - 1;
        end
        else if (holdoff_request > 0)
        begin
            record_stall <= 1'b1;
            holdoff_left = holdoff_request - 1;
            holdoff_request = 0;
        end
        else if (no_gaps)
        begin
            record_stall <= 1'b0;
        end
        else
        begin
            record_stall <= ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    task automatic compare_field(input string name, input logic [25:0] want,
                                 input logic [25:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // every record transfer is held against the oldest owed record
    always @(posedge clk)
    begin
        rtwd_pkg::record_t want;
        if (rst_n && record_valid && !record_stall)
        begin
            if (due_records.size() == 0)
            begin
                $display("%0t: unexpected record, expected none, got %0d %0d %h %0d",
                         $time, record_data.status, record_data.field_id,
                         record_data.field_value, record_data.last);
                mismatch_count++;
            end
            else
            begin
                want = due_records.pop_front();
                compare_field("status",      26'(want.status),   26'(record_data.status));
                compare_field("field_id",    26'(want.field_id), 26'(record_data.field_id));
                compare_field("field_value", want.field_value,   record_data.field_value);
                compare_field("last",        26'(want.last),     26'(record_data.last));
            end
        end
    end

    // watchdog: too long without any transfer on either side
    always @(posedge clk)
    begin
        if ((word_valid && !word_stall) || (record_valid && !record_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STUCK_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d records still owed",
                     $time, STUCK_LIMIT, due_records.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // start words the decoder must reject, and words it must drop while idle
    task automatic test_rejected_starts();
        send_word(32'h0000_0000, 1'b1);
        send_word(make_last_word(MARK_OTHER, 6'h15, 8'h5A, 9'h0A5, 7'h2A), 1'b1);
        send_word({rtwd_pkg::MARK_PARAM, 30'h3FFF_FFFF}, 1'b1);
        send_word(make_last_word(rtwd_pkg::MARK_LAST, 6'h3F, 8'hFF, 9'h1FF, 7'd0), 1'b1);
        send_word(make_last_word(rtwd_pkg::MARK_LAST, 6'h00, 8'h00, 9'h000, 7'd1), 1'b1);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b0);
    endtask

    // size two: start and payload only; then a payload word that lacks its marker
    task automatic test_shortest_trailer();
        send_word(make_last_word(rtwd_pkg::MARK_LAST, 6'h3F, 8'hFF, 9'h1FF,
                                 rtwd_pkg::MIN_SIZE), 1'b1);
        send_word(make_param_word(rtwd_pkg::MARK_PARAM, PCODE_TOP, 26'h3FF_FFFF), 1'b0);
        send_word(make_last_word(rtwd_pkg::MARK_LAST, 6'h00, 8'h01, 9'h100,
                                 rtwd_pkg::MIN_SIZE), 1'b1);
        send_word(make_param_word(rtwd_pkg::MARK_LAST, PCODE_NONE, 26'h155_5555), 1'b0);
    endtask

    // every known code with all data bits set, plus the two corrupt-code extremes
    task automatic test_every_parameter_code();
        send_word(make_last_word(rtwd_pkg::MARK_LAST, 6'h00, 8'h00, 9'h000, 7'd11), 1'b1);
        send_word(make_param_word(rtwd_pkg::MARK_PARAM, rtwd_pkg::PCODE_FEC,
                                  26'h3FF_FFFF), 1'b0);
        send_word(make_param_word(rtwd_pkg::MARK_PARAM, rtwd_pkg::PCODE_REG_TWO,
                                  26'h3FF_FFFF), 1'b0);
        send_word(make_param_word(rtwd_pkg::MARK_PARAM, rtwd_pkg::PCODE_REG_THREE,
                                  26'h3FF_FFFF), 1'b0);
        send_word(make_param_word(rtwd_pkg::MARK_PARAM, rtwd_pkg::PCODE_ACT_A,
                                  26'h3FF_FFFF), 1'b0);
        send_word(make_param_word(rtwd_pkg::MARK_PARAM, rtwd_pkg::PCODE_ACT_B,
                                  26'h3FF_FFFF), 1'b0);
        send_word(make_param_word(rtwd_pkg::MARK_PARAM, rtwd_pkg::PCODE_CFG_ONE,
                                  26'h3FF_FFFF), 1'b0);
        send_word(make_param_word(rtwd_pkg::MARK_PARAM, rtwd_pkg::PCODE_CFG_TWO,
                                  26'h3FF_FFFF), 1'b0);
        send_word(make_param_word(rtwd_pkg::MARK_PARAM, PCODE_NONE, 26'h3FF_FFFF), 1'b0);
        send_word(make_param_word(rtwd_pkg::MARK_PARAM, PCODE_TOP,  26'h000_0000), 1'b0);
        send_word(make_param_word(rtwd_pkg::MARK_PARAM, PCODE_NONE, 26'h000_0000), 1'b0);
    endtask

    // a new start part-way through a full-size trailer throws the old one away
    task automatic test_restart_mid_trailer();
        send_word(make_last_word(rtwd_pkg::MARK_LAST, 6'h2A, 8'h3C, 9'h0C3, MAX_SIZE), 1'b1);
        send_word(make_param_word(rtwd_pkg::MARK_PARAM, rtwd_pkg::PCODE_FEC,
                                  26'h2AB_CDEF), 1'b0);
        send_word(make_last_word(rtwd_pkg::MARK_LAST, 6'h15, 8'hC3, 9'h13C,
                                 rtwd_pkg::MIN_SIZE), 1'b1);
        send_word(make_param_word(rtwd_pkg::MARK_PARAM, rtwd_pkg::PCODE_ACT_A,
                                  26'h123_4567), 1'b0);
    endtask

    // receiver holds off while short trailers keep coming, so the word side backs up
    task automatic test_receiver_holdoff();
        holdoff_request = HOLDOFF_CYCLES;
        repeat (4)
            send_trailer(rtwd_pkg::MIN_SIZE, 1'b0);
        wait_drained();
    endtask

    // mostly well-formed trailers with random content, some noise and broken ones
    task automatic test_random_traffic();
        int unsigned goal;
        int unsigned pick;
        logic [31:0] rnd;
        goal = ITEM_TARGET;
        while (items_sent < goal)
        begin
            // a stretch in the middle with no idling on either side
            no_gaps = (items_sent + 110 > goal) && (items_sent + 55 < goal);
            pick = $urandom_range(99);
            rnd  = $urandom;
            if (pick < 68)
                send_trailer(9, 1'b0);
            else if (pick < 76)
                send_word({stray_marker(), rnd[29:0]}, 1'b1);
            else if (pick < 82)
                send_word(make_last_word(rtwd_pkg::MARK_LAST, rnd[29:24], rnd[23:16],
                                         rnd[15:7], 7'($urandom_range(1))), 1'b1);
            else if (pick < 90)
                send_trailer(9, 1'b1);
            else
                repeat ($urandom_range(3, 1))
                    send_word($urandom, 1'b0);
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_rejected_starts();
        wait_drained();
        test_shortest_trailer();
        wait_drained();
        test_every_parameter_code();
        wait_drained();
        test_restart_mid_trailer();
        wait_drained();
        test_receiver_holdoff();
        test_random_traffic();
        wait_drained();

        // give a stray extra record time to show up
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/rtwd_pkg.sv
rtl/rtwd_decode.sv
rtl/rtwd_emit.sv
rtl/readout_trailer_word_decoder_unit.sv
bench/readout_trailer_word_decoder_unit_tb.sv
